FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 8;
    localparam int TAG_W         = 16;
    localparam int FILL_W        = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } spq_action_t;

    typedef struct packed {
        spq_action_t       action;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  order_tag;
    } spq_req_t;

    typedef struct packed {
        logic              out_valid;
        logic [TAG_W-1:0]  out_tag;
        logic [PRIO_W-1:0] out_priority;
        logic              refused;
        logic [FILL_W-1:0] fill_count;
    } spq_rsp_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } spq_entry_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic       do_insert;
        logic       do_remove;
        spq_entry_t new_entry;
    } spq_ctrl_t;

endpackage

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus the
// fill counter and the registered response. Uses spq_pkg and spq_cell.

// A bounded priority queue of DEPTH entries kept sorted by descending
// priority, head in cell 0. Each request either inserts an entry (priority,
// order tag) behind every held entry of equal or higher priority, so equal
// priorities leave in arrival order, or removes the head entry. Every request
// yields exactly one response carrying out_valid (an entry was removed), the
// removed tag and priority (zero otherwise), refused (insert when full or
// remove when empty; the queue is left unchanged) and fill_count, the number
// of entries held afterwards, truncated to five bits. The chain of cells
// compares all slots against the incoming priority at once and shifts the
// chain together, and the block takes one request per cycle while the response
// slot is free or being drained; the response sits in an output register, and a new
// request is taken in the same cycle the waiting response is taken. Entry
// storage is not reset: a slot is only read once it has been written.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_rsp_t m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    spq_ctrl_t        ctrl;
    logic             accept;
    logic             full;
    logic             empty;

    logic             ge_chain [DEPTH];
    spq_entry_t       entries  [DEPTH];

    // Take a request whenever the response slot is free or is being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    assign ctrl.do_insert = accept && (s_data.action == ACT_INSERT) && !full;
    assign ctrl.do_remove = accept && (s_data.action == ACT_REMOVE) && !empty;
    assign ctrl.new_entry.prio = s_data.priority_req;
    assign ctrl.new_entry.tag  = s_data.order_tag;

    // Chain of slots. Cell 0 sees an always-ahead left neighbor so a new
    // highest entry lands at the head; the last cell pulls an unused value
    // on remove, which lands beyond the fill count.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic       l_ge;
        spq_entry_t l_entry;
        spq_entry_t r_entry;

        if (i == 0) begin : g_head
            assign l_ge    = 1'b1;
            assign l_entry = ctrl.new_entry;
        end else begin : g_body
            assign l_ge    = ge_chain[i-1];
            assign l_entry = entries[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign r_entry = ctrl.new_entry;
        end else begin : g_mid
            assign r_entry = entries[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(i) < count_reg),
            .left_ge     (l_ge),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .ge          (ge_chain[i]),
            .entry       (entries[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rsp_next     = rsp_reg;
        if (ctrl.do_insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept) begin
            m_valid_next          = 1'b1;
            rsp_next.out_valid    = ctrl.do_remove;
            rsp_next.out_tag      = ctrl.do_remove ? entries[0].tag  : '0;
            rsp_next.out_priority = ctrl.do_remove ? entries[0].prio : '0;
            rsp_next.refused      = !(ctrl.do_insert || ctrl.do_remove);
            rsp_next.fill_count   = FILL_W'(count_next);
        end else if (m_ready) begin
            // drop the delivered response
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds one entry, compares it with the
// broadcast insert entry and shifts toward either neighbor. Uses spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  spq_ctrl_t  ctrl,
    input  logic       occupied,
    input  logic       left_ge,
    input  spq_entry_t left_entry,
    input  spq_entry_t right_entry,
    output logic       ge,
    output spq_entry_t entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // Stays ahead of the new entry: occupied and of equal or higher priority.
    assign ge    = occupied && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.do_insert) begin
            if (ge) begin
                entry_next = entry_reg;
            end else if (left_ge) begin
                entry_next = ctrl.new_entry;
            end else begin
                entry_next = left_entry;
            end
        end else if (ctrl.do_remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: verif/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: directed and random
// insert/remove traffic checked against a sorted-list predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;
    // Worst legal quiet stretch is the long receiver hold-off (HOLD_CYCLES)
    // plus the output register; allow many times that before giving up.
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    spq_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    spq_rsp_t m_data;

    // Shadow of the queue contents, head at index 0.
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [TAG_W-1:0]  shadow_tag  [DEPTH];
    int                shadow_count = 0;

    spq_rsp_t    pending_rsp[$];
    int unsigned error_count   = 0;
    int unsigned hold_off_len  = 0;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one request to the shadow queue and return the response it must
    // produce. Inserts go behind every entry of equal or higher priority so
    // that ties leave in arrival order; refused requests leave state alone.
    function automatic spq_rsp_t predict_response(input spq_req_t req);
        spq_rsp_t rsp;
        int       pos;
        int       k;
        rsp = '0;
        if (req.action == ACT_INSERT) begin
            if (shadow_count >= DEPTH) begin
                rsp.refused = 1'b1;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= req.priority_req)
                    pos++;
                for (k = shadow_count; k > pos; k--) begin
                    shadow_prio[k] = shadow_prio[k-1];
                    shadow_tag[k]  = shadow_tag[k-1];
                end
                shadow_prio[pos] = req.priority_req;
                shadow_tag[pos]  = req.order_tag;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                rsp.refused = 1'b1;
            end else begin
                rsp.out_valid    = 1'b1;
                rsp.out_priority = shadow_prio[0];
                rsp.out_tag      = shadow_tag[0];
                for (k = 1; k < shadow_count; k++) begin
                    shadow_prio[k-1] = shadow_prio[k];
                    shadow_tag[k-1]  = shadow_tag[k];
                end
                shadow_count--;
            end
        end
        rsp.fill_count = FILL_W'(shadow_count);
        return rsp;
    endfunction

    function automatic spq_req_t make_request(input spq_action_t act,
                                              input logic [PRIO_W-1:0] prio,
                                              input logic [TAG_W-1:0] tag);
        spq_req_t req;
        req.action       = act;
        req.priority_req = prio;
        req.order_tag    = tag;
        return req;
    endfunction

    // Random request: priorities lean toward ties and the extremes so that
    // ordering among equals and head/tail placement get plenty of traffic.
    function automatic spq_req_t random_request(input int unsigned insert_pct);
        spq_action_t       act;
        logic [PRIO_W-1:0] prio;
        act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
        case ($urandom_range(0, 3))
            0: prio = PRIO_W'($urandom_range(126, 129));
            1: prio = $urandom_range(0, 1) ? '1 : '0;
            default: prio = PRIO_W'($urandom_range(0, 255));
        endcase
        return make_request(act, prio, TAG_W'($urandom_range(0, 65535)));
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        error_count++;
    endtask

    // Offer one request and hold it until accepted. Call right after a rising
    // edge; a back-to-back call leaves valid high without a low pulse.
    task automatic send_request(input spq_req_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Remove on empty, extreme fields, ties at one priority, and draining the
    // last entry so the queue reports empty again.
    task automatic test_empty_and_extremes();
        send_request(make_request(ACT_REMOVE, '1, '1));
        send_request(make_request(ACT_INSERT, 8'h00, 16'h0000));
        send_request(make_request(ACT_INSERT, 8'hFF, 16'hFFFF));
        send_request(make_request(ACT_INSERT, 8'h80, 16'h1111));
        send_request(make_request(ACT_INSERT, 8'h80, 16'h2222));
        send_request(make_request(ACT_INSERT, 8'h81, 16'h5A5A));
        send_request(make_request(ACT_INSERT, 8'h80, 16'h3333));
        repeat (6) send_request(make_request(ACT_REMOVE, 8'h55, 16'hA5A5));
        send_request(make_request(ACT_REMOVE, 8'h00, 16'h0000));
        idle_gap(3);
    endtask

    // Fill to capacity with head, tail and middle inserts plus ties, try one
    // insert too many, then drain past empty.
    task automatic test_full_and_drain();
        int k;
        for (k = 0; k < DEPTH; k++)
            send_request(make_request(ACT_INSERT, PRIO_W'((k * 7) % 5 * 60),
                                      TAG_W'(16'hA000 + k)));
        send_request(make_request(ACT_INSERT, '1, 16'hDEAD));
        for (k = 0; k <= DEPTH; k++)
            send_request(make_request(ACT_REMOVE, '0, '0));
        idle_gap(2);
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_backpressure(input int unsigned n_items);
        int unsigned k;
        hold_off_len = HOLD_CYCLES;
        for (k = 0; k < n_items; k++)
            send_request(random_request(60));
    endtask

    // Random traffic in phases that lean toward filling, draining or mixing,
    // sent in bursts of random length with random gaps between them.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned phase_left;
        int unsigned burst_left;
        int unsigned insert_pct;
        sent       = 0;
        phase_left = 0;
        burst_left = 0;
        insert_pct = 50;
        while (sent < n_items) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    2: insert_pct = 50;
                    default: insert_pct = 65;
                endcase
                phase_left = $urandom_range(8, 64);
            end
            if (burst_left == 0) begin
                // Leave roughly a quarter of the bursts back to back.
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            send_request(random_request(insert_pct));
            sent++;
            phase_left--;
            burst_left--;
        end
    endtask

    // Receiver: pick a stall pattern for a stretch of cycles, and honor a
    // requested hold-off by dropping ready for that many cycles.
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned span;
        int unsigned hold;
        int unsigned tick;
        mode = RX_ALWAYS;
        span = 0;
        tick = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_len > 0) begin
                hold         = hold_off_len;
                hold_off_len = 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(10, 150);
            end
            span--;
            tick++;
            case (mode)
                RX_ALWAYS:   m_ready <= 1'b1;
                RX_MOSTLY:   m_ready <= ($urandom_range(0, 9) < 7);
                RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= ((tick % 4) != 3);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // Predict on every accepted request; check every accepted response
    // against the oldest prediction, field by field.
    always @(posedge aclk) begin : response_check
        spq_rsp_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_rsp.push_back(predict_response(s_data));
            if (m_valid && m_ready) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response", m_data, 0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (m_data.out_valid !== want.out_valid)
                        report_mismatch("out_valid", m_data.out_valid, want.out_valid);
                    if (m_data.out_tag !== want.out_tag)
                        report_mismatch("out_tag", m_data.out_tag, want.out_tag);
                    if (m_data.out_priority !== want.out_priority)
                        report_mismatch("out_priority", m_data.out_priority,
                                        want.out_priority);
                    if (m_data.refused !== want.refused)
                        report_mismatch("refused", m_data.refused, want.refused);
                    if (m_data.fill_count !== want.fill_count)
                        report_mismatch("fill_count", m_data.fill_count,
                                        want.fill_count);
                end
            end
        end
    end

    // End the run if neither channel moves a request for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : main_sequence
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_extremes();
        test_full_and_drain();
        test_output_backpressure(40);
        test_random_traffic(1460);

        // Drop valid, wait for every predicted response, then settle.
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
